// ----- rtl/core/cfpf_pkg.sv -----
// Shared types, constants and arithmetic helpers for the cross five-point RGB filter.
// Used by the top level, the output queue and the testbench; depends on nothing else.
package cfpf_pkg;

  localparam int IMAGE_WIDTH  = 128;
  localparam int IMAGE_HEIGHT = 128;

  localparam int COL_W = $clog2(IMAGE_WIDTH);
  localparam int ROW_W = $clog2(IMAGE_HEIGHT);

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int POS_W = 7;

  // Line store entry: pixel two rows up in the upper half, one row up in the lower half.
  localparam int ENTRY_W = 2 * PIX_W;

  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } out_beat_t;

  // Exact floor(v / 5) for an 8-bit value: multiply by 205 and drop ten bits.
  function automatic logic [CH_W-1:0] fifth(input logic [CH_W-1:0] v);
    logic [2*CH_W-1:0] prod;
    prod = v * 8'd205;
    return {2'b00, prod[15:10]};
  endfunction

  // Sum of the five scaled taps of one channel. The total is at most 255.
  function automatic logic [CH_W-1:0] cross_sum(input logic [CH_W-1:0] up,
                                                input logic [CH_W-1:0] lf,
                                                input logic [CH_W-1:0] ct,
                                                input logic [CH_W-1:0] rt,
                                                input logic [CH_W-1:0] dn);
    return fifth(up) + fifth(lf) + fifth(ct) + fifth(rt) + fifth(dn);
  endfunction

endpackage

// ----- rtl/core/cfpf_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; holds no reset and no initial contents.
module cfpf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cfpf_out_fifo.sv -----
// Two-beat output queue that decouples the filter pipeline from the result consumer.
// Depends on cfpf_pkg for the result beat type and the queue depth.
module cfpf_out_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  cfpf_pkg::out_beat_t               beat_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output cfpf_pkg::out_beat_t               beat_o,
  output logic [cfpf_pkg::OUT_CNT_W-1:0]    count_o
);

  cfpf_pkg::out_beat_t                  slot_q [cfpf_pkg::OUT_DEPTH];
  logic [cfpf_pkg::OUT_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [cfpf_pkg::OUT_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [cfpf_pkg::OUT_CNT_W-1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == cfpf_pkg::OUT_PTR_W'(cfpf_pkg::OUT_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == cfpf_pkg::OUT_PTR_W'(cfpf_pkg::OUT_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= beat_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign beat_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ----- rtl/core/cross_five_point_rgb_filter.sv -----
// Cross five-point RGB filter: top level with position tracking, line store and kernel.
// Depends on cfpf_pkg, cfpf_ram and cfpf_out_fifo.

// The block takes one RGB pixel beat per clock in raster order and filters each colour
// channel on its own with a plus-shaped kernel: the centre and its four neighbours each
// contribute floor(p/5), so a full-scale input gives at most 255. Only interior pixels
// give a result beat, which stage 2 forms and queues after the beat of the pixel
// directly below the centre is taken; border pixels give none. A pixel beat with
// frame_start high lands at row 0, column 0; without it the position wraps by itself
// after the last pixel of the frame. Sustained throughput is one pixel per clock: the
// line store is read the cycle a pixel is taken and written back the next cycle, and
// a same-address read in that cycle is served by forwarding, so no pixel ever waits on
// the store. Input ready drops when the beats already in the two-beat result queue,
// plus one for the pixel still in the pipeline and less one for a beat leaving this
// cycle, would leave no room for another result; with the consumer always ready this
// never happens. The line store has no reset and needs no clearing pass: the first two
// rows of a frame never produce results, so unwritten entries never show.
module cross_five_point_rgb_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic [6:0] out_row_o,
  output logic [6:0] out_col_o,
  output logic       last_of_frame_o
);

  // ---------------------------------------------------------------------------
  // Position of the next pixel in the frame.
  // ---------------------------------------------------------------------------
  cfpf_pkg::col_t col_q, col_d;
  cfpf_pkg::row_t row_q, row_d;
  cfpf_pkg::col_t cur_col;
  cfpf_pkg::row_t cur_row;
  cfpf_pkg::col_t next_col;
  cfpf_pkg::pix_t in_pix;
  logic           in_accept;
  logic           col_is_last;

  assign in_accept   = in_valid_i && in_ready_o;
  assign in_pix      = {red_in_i, green_in_i, blue_in_i};
  assign cur_col     = frame_start_i ? '0 : col_q;
  assign cur_row     = frame_start_i ? '0 : row_q;
  assign col_is_last = (cur_col == cfpf_pkg::COL_W'(cfpf_pkg::IMAGE_WIDTH - 1));
  assign next_col    = col_is_last ? '0 : cur_col + 1'b1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      col_d = next_col;
      row_d = cur_row;
      if (col_is_last) begin
        row_d = (cur_row == cfpf_pkg::ROW_W'(cfpf_pkg::IMAGE_HEIGHT - 1)) ?
                '0 : cur_row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the pixel has been taken and the line store reads are in flight.
  // Store A holds both rows above at the pixel's column; store B gives the row above
  // at the next column, the right-hand neighbour of the centre.
  // ---------------------------------------------------------------------------
  logic                           s1_valid_q;
  cfpf_pkg::pix_t                 s1_pix_q;
  cfpf_pkg::col_t                 s1_col_q;
  logic                           s1_emit_q;
  logic                           s1_last_q;
  logic [cfpf_pkg::POS_W-1:0]     s1_out_row_q;
  logic [cfpf_pkg::POS_W-1:0]     s1_out_col_q;
  logic                           hit_a_q, hit_b_q;
  logic [cfpf_pkg::ENTRY_W-1:0]   fwd_a_q;
  cfpf_pkg::pix_t                 fwd_b_q;

  logic                           emit_d;
  logic                           last_d;
  logic [cfpf_pkg::ENTRY_W-1:0]   wr_entry;
  logic [cfpf_pkg::ENTRY_W-1:0]   rd_a;
  cfpf_pkg::pix_t                 rd_b;

  assign emit_d = (cur_row >= cfpf_pkg::ROW_W'(2)) && (cur_col != '0) && !col_is_last;
  assign last_d = (cur_row == cfpf_pkg::ROW_W'(cfpf_pkg::IMAGE_HEIGHT - 1)) &&
                  (cur_col == cfpf_pkg::COL_W'(cfpf_pkg::IMAGE_WIDTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  // The pixel in stage 2 writes its column while the next pixel reads; the write data
  // is captured with each taken pixel, with a flag for each store read that hits it.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q     <= in_pix;
      s1_col_q     <= cur_col;
      s1_emit_q    <= emit_d;
      s1_last_q    <= last_d;
      s1_out_row_q <= cfpf_pkg::POS_W'(cur_row - 1'b1);
      s1_out_col_q <= cfpf_pkg::POS_W'(cur_col);
      hit_a_q      <= s1_valid_q && (s1_col_q == cur_col);
      hit_b_q      <= s1_valid_q && (s1_col_q == next_col);
      fwd_a_q      <= wr_entry;
      fwd_b_q      <= s1_pix_q;
    end
  end

  cfpf_ram #(
    .Width (cfpf_pkg::ENTRY_W),
    .Depth (cfpf_pkg::IMAGE_WIDTH)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (wr_entry),
    .re_i    (in_accept),
    .raddr_i (cur_col),
    .rdata_o (rd_a)
  );

  cfpf_ram #(
    .Width (cfpf_pkg::PIX_W),
    .Depth (cfpf_pkg::IMAGE_WIDTH)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (in_accept),
    .raddr_i (next_col),
    .rdata_o (rd_b)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: kernel and write-back. The left neighbour is the centre of the pixel
  // before, which for any pixel off column 0 was at the column just to the left.
  // ---------------------------------------------------------------------------
  logic [cfpf_pkg::ENTRY_W-1:0] entry_a;
  cfpf_pkg::pix_t               tap_up, tap_lf, tap_ct, tap_rt, tap_dn;
  cfpf_pkg::pix_t               left_q;
  cfpf_pkg::out_beat_t          beat;
  logic                         push;
  logic                         pop;
  logic [cfpf_pkg::OUT_CNT_W-1:0] fifo_count;
  logic [cfpf_pkg::OUT_CNT_W:0]   fifo_load;

  assign entry_a  = hit_a_q ? fwd_a_q : rd_a;
  assign tap_up   = entry_a[cfpf_pkg::ENTRY_W-1:cfpf_pkg::PIX_W];
  assign tap_ct   = entry_a[cfpf_pkg::PIX_W-1:0];
  assign tap_rt   = hit_b_q ? fwd_b_q : rd_b;
  assign tap_lf   = left_q;
  assign tap_dn   = s1_pix_q;
  assign wr_entry = {tap_ct, s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      left_q <= tap_ct;
    end
  end

  assign beat.red   = cfpf_pkg::cross_sum(tap_up[23:16], tap_lf[23:16], tap_ct[23:16],
                                          tap_rt[23:16], tap_dn[23:16]);
  assign beat.green = cfpf_pkg::cross_sum(tap_up[15:8], tap_lf[15:8], tap_ct[15:8],
                                          tap_rt[15:8], tap_dn[15:8]);
  assign beat.blue  = cfpf_pkg::cross_sum(tap_up[7:0], tap_lf[7:0], tap_ct[7:0],
                                          tap_rt[7:0], tap_dn[7:0]);
  assign beat.row   = s1_out_row_q;
  assign beat.col   = s1_out_col_q;
  assign beat.last  = s1_last_q;

  assign push = s1_valid_q && s1_emit_q;
  assign pop  = out_valid_o && out_ready_i;

  // Take a pixel only if the queue is sure to have room when its result arrives.
  assign fifo_load  = (cfpf_pkg::OUT_CNT_W+1)'(fifo_count) +
                      (cfpf_pkg::OUT_CNT_W+1)'(s1_valid_q);
  assign in_ready_o = pop ? (fifo_load <= (cfpf_pkg::OUT_CNT_W+1)'(cfpf_pkg::OUT_DEPTH)) :
                            (fifo_load <  (cfpf_pkg::OUT_CNT_W+1)'(cfpf_pkg::OUT_DEPTH));

  cfpf_pkg::out_beat_t out_beat;

  cfpf_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .beat_i  (beat),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .beat_o  (out_beat),
    .count_o (fifo_count)
  );

  assign red_out_o       = out_beat.red;
  assign green_out_o     = out_beat.green;
  assign blue_out_o      = out_beat.blue;
  assign out_row_o       = out_beat.row;
  assign out_col_o       = out_beat.col;
  assign last_of_frame_o = out_beat.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_s1_follows_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(in_accept))
    else $error("stage 1 holds a pixel that was never taken");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (fifo_count < cfpf_pkg::OUT_CNT_W'(cfpf_pkg::OUT_DEPTH)))
    else $error("result queue written while full");

  a_col_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (col_q == $past(next_col)))
    else $error("column position did not advance after a pixel");

  a_fwd_needs_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (hit_a_q || hit_b_q)) |-> $past(s1_valid_q))
    else $error("forwarded store data without a write in flight");

  a_emit_interior : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (s1_col_q != '0))
    else $error("result produced for a border column");

endmodule

// ----- sim/cross_five_point_rgb_filter_tb.sv -----
// Self-checking testbench for cross_five_point_rgb_filter: streams RGB pixel frames in
// raster order and checks every filtered result beat against an in-bench line-buffer model.
// Depends on cfpf_pkg and the filter RTL.
`timescale 1ns / 1ps

module cross_five_point_rgb_filter_tb;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_beat_t;

  logic       clk_i;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] red_in_i       = '0;
  logic [7:0] green_in_i     = '0;
  logic [7:0] blue_in_i      = '0;
  logic       frame_start_i  = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic [6:0] out_row_o;
  logic [6:0] out_col_o;
  logic       last_of_frame_o;

  cross_five_point_rgb_filter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // Pixels waiting to be offered, and filtered results the block still owes us.
  pixel_beat_t         pixel_q[$];
  cfpf_pkg::out_beat_t filtered_q[$];

  int mismatch_cnt   = 0;
  int pixels_taken   = 0;
  int markers_taken  = 0;
  int results_seen   = 0;
  int frame_ends     = 0;
  int cycle_cnt      = 0;

  // Model of the filter's own state: for every column the pixels one and two rows up,
  // the three-wide window over the row above, and where the next pixel will land.
  logic [47:0] rows_above_mem [cfpf_pkg::IMAGE_WIDTH];
  logic [23:0] above_win [3];
  int          next_row = 0;
  int          next_col = 0;

  // Both sides may idle, except during one long stretch where everything runs flat out.
  logic idle_allowed;
  assign idle_allowed = !(cycle_cnt >= 250 && cycle_cnt < 450);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_cnt++;
  endtask

  // One channel of one tap, already divided by five and rounded down.
  function automatic int fifth_of(input logic [23:0] px, input int shift);
    return int'((px >> shift) & 24'hFF) / 5;
  endfunction

  function automatic logic [7:0] plus_sum(input logic [23:0] up, lf, ct, rt, dn,
                                          input int shift);
    int total;
    total = fifth_of(up, shift) + fifth_of(lf, shift) + fifth_of(ct, shift) +
            fifth_of(rt, shift) + fifth_of(dn, shift);
    return total[7:0];
  endfunction

  // Advance the model by one accepted pixel and queue the result it completes, if any.
  task automatic predict_pixel(input pixel_beat_t beat);
    logic [23:0]         px;
    logic [23:0]         two_up;
    logic [23:0]         one_up;
    cfpf_pkg::out_beat_t want;
    int                  r;
    int                  c;
    px = {beat.red, beat.green, beat.blue};
    r  = next_row;
    c  = next_col;
    if (beat.frame_start || r >= cfpf_pkg::IMAGE_HEIGHT || c >= cfpf_pkg::IMAGE_WIDTH) begin
      r = 0;
      c = 0;
    end
    two_up = rows_above_mem[c][47:24];
    one_up = rows_above_mem[c][23:0];
    if (c == 0) begin
      above_win[0] = '0;
      above_win[1] = one_up;
    end else begin
      above_win[0] = above_win[1];
      above_win[1] = above_win[2];
    end
    above_win[2] = (c + 1 < cfpf_pkg::IMAGE_WIDTH) ? rows_above_mem[c + 1][23:0] : '0;

    // The centre sits one row up; the new pixel is the tap below it.
    if (r >= 2 && c >= 1 && c + 1 < cfpf_pkg::IMAGE_WIDTH) begin
      want.red   = plus_sum(two_up, above_win[0], above_win[1], above_win[2], px, 16);
      want.green = plus_sum(two_up, above_win[0], above_win[1], above_win[2], px, 8);
      want.blue  = plus_sum(two_up, above_win[0], above_win[1], above_win[2], px, 0);
      want.row   = 7'(r - 1);
      want.col   = 7'(c);
      want.last  = (r == cfpf_pkg::IMAGE_HEIGHT - 1 && c == cfpf_pkg::IMAGE_WIDTH - 2);
      filtered_q.push_back(want);
    end

    rows_above_mem[c] = {one_up, px};
    c++;
    if (c >= cfpf_pkg::IMAGE_WIDTH) begin
      c = 0;
      r = (r + 1 >= cfpf_pkg::IMAGE_HEIGHT) ? 0 : r + 1;
    end
    next_row = r;
    next_col = c;
  endtask

  // Channel levels lean towards the edges of the range and the steps of the divide by five.
  function automatic logic [7:0] pick_level();
    logic [7:0] corner [7] = '{8'd0, 8'd4, 8'd5, 8'd9, 8'd250, 8'd254, 8'd255};
    if ($urandom_range(3) == 0) return corner[$urandom_range(6)];
    return 8'($urandom);
  endfunction

  task automatic queue_pixel(input logic [7:0] red, green, blue, input logic marker);
    pixel_beat_t beat;
    beat.red         = red;
    beat.green       = green;
    beat.blue        = blue;
    beat.frame_start = marker;
    pixel_q.push_back(beat);
  endtask

  // A run of pixels from the current position. A banded run carries a band of white
  // columns and a band of black columns so that the filter sees flat full-scale and
  // zero areas. Unmarked pixels of a noisy run now and then carry a stray frame marker.
  task automatic queue_run(input int n_pix, input bit marked, input bit banded,
                           input bit noisy);
    int  col;
    for (int i = 0; i < n_pix; i++) begin
      col = i % cfpf_pkg::IMAGE_WIDTH;
      if (banded && col >= 20 && col < 40) begin
        queue_pixel(8'hFF, 8'hFF, 8'hFF, marked && i == 0);
      end else if (banded && col >= 40 && col < 60) begin
        queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      end else begin
        queue_pixel(pick_level(), pick_level(), pick_level(),
                    (marked && i == 0) || (noisy && i > 0 && $urandom_range(299) == 0));
      end
    end
  endtask

  // Driver: offers the next pending pixel, holding it steady until it is taken.
  always @(posedge clk_i) begin
    pixel_beat_t taken;
    pixel_beat_t beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        taken.red         = red_in_i;
        taken.green       = green_in_i;
        taken.blue        = blue_in_i;
        taken.frame_start = frame_start_i;
        predict_pixel(taken);
        pixels_taken++;
        if (frame_start_i) markers_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pixel_q.size() > 0 && !(idle_allowed && $urandom_range(99) < 16)) begin
          beat = pixel_q.pop_front();
          in_valid_i    <= 1'b1;
          red_in_i      <= beat.red;
          green_in_i    <= beat.green;
          blue_in_i     <= beat.blue;
          frame_start_i <= beat.frame_start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest expectation, stalling at random.
  always @(posedge clk_i) begin
    cfpf_pkg::out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (last_of_frame_o) frame_ends++;
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat at row %0d col %0d",
                                    out_row_o, out_col_o));
        end else begin
          want = filtered_q.pop_front();
          if (red_out_o !== want.red)
            report_mismatch($sformatf("red %0d, expected %0d at (%0d,%0d)",
                                      red_out_o, want.red, want.row, want.col));
          if (green_out_o !== want.green)
            report_mismatch($sformatf("green %0d, expected %0d at (%0d,%0d)",
                                      green_out_o, want.green, want.row, want.col));
          if (blue_out_o !== want.blue)
            report_mismatch($sformatf("blue %0d, expected %0d at (%0d,%0d)",
                                      blue_out_o, want.blue, want.row, want.col));
          if (out_row_o !== want.row)
            report_mismatch($sformatf("row %0d, expected %0d", out_row_o, want.row));
          if (out_col_o !== want.col)
            report_mismatch($sformatf("column %0d, expected %0d", out_col_o, want.col));
          if (last_of_frame_o !== want.last)
            report_mismatch($sformatf("frame end flag %0d, expected %0d at (%0d,%0d)",
                                      last_of_frame_o, want.last, want.row, want.col));
        end
      end
      out_ready_i <= !(idle_allowed && $urandom_range(99) < 16);
    end
  end

  initial begin
    #10_000_000;
    $display("[cross_five_point_rgb_filter] ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < cfpf_pkg::IMAGE_WIDTH; i++) rows_above_mem[i] = '0;
    foreach (above_win[i]) above_win[i] = '0;

    // Directed opening: channel extremes, frame markers at the very start and mid-row.
    queue_pixel(8'd255, 8'd0,   8'd128, 1'b1);
    queue_pixel(8'd0,   8'd255, 8'd1,   1'b0);
    queue_pixel(8'd4,   8'd5,   8'd9,   1'b0);
    queue_pixel(8'd10,  8'd250, 8'd254, 1'b0);
    queue_pixel(8'hAA,  8'h55,  8'hAA,  1'b0);
    queue_pixel(8'h55,  8'hAA,  8'h55,  1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    queue_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    queue_pixel(8'd254, 8'd249, 8'd6,   1'b0);
    queue_pixel(8'd1,   8'd2,   8'd3,   1'b1);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd0,   8'd0,   8'd0,   1'b0);

    // A marked run of two rows and a bit with flat white and black bands, so that part
    // of row 1 gives results.
    queue_run(2 * cfpf_pkg::IMAGE_WIDTH + 60, 1'b1, 1'b1, 1'b0);

    // A short run broken off by a fresh marker, then a marked noisy run deep enough to
    // give results, with the odd stray marker mixed in.
    queue_run($urandom_range(30, 5), 1'b1, 1'b0, 1'b1);
    queue_run(2 * cfpf_pkg::IMAGE_WIDTH + 20, 1'b1, 1'b0, 1'b1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || filtered_q.size() != 0);
    repeat (20) @(posedge clk_i);

    if (filtered_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", filtered_q.size()));

    $display("Streamed %0d pixel beats with %0d frame markers.", pixels_taken, markers_taken);
    $display("Checked %0d filtered beats, %0d of them frame ends; %0d mismatches.",
             results_seen, frame_ends, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("[cross_five_point_rgb_filter] OK");
    end else begin
      $display("[cross_five_point_rgb_filter] ERROR");
    end
    $finish;
  end

endmodule
